// File: design/zobrist_position_hash_macros.svh
// Assertion macros used by the checker of the position hash block.
`ifndef ZOBRIST_POSITION_HASH_MACROS_SVH
`define ZOBRIST_POSITION_HASH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ZPH_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ZPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/zph_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package zph_pkg;

    localparam int KEY_W = 64;
    localparam int HALF_W = KEY_W / 2;
    localparam int SQUARES = 64;
    localparam int SQ_W = $clog2(SQUARES);
    localparam int KIND_FIELD_W = 4;
    localparam int FLAGS_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam int PIECE_KINDS_DEF = 12;
    localparam int CASTLE_RIGHTS_DEF = 4;

    // Generator constants: x' = x * LCG_MUL + LCG_ADD, modulo 2^64.
    localparam logic [KEY_W-1:0] LCG_MUL = 64'd8 * 64'd893636665409536 - 64'd3;
    localparam logic [KEY_W-1:0] LCG_ADD = 64'd4354685564936845319;
    localparam logic [HALF_W-1:0] LCG_MUL_LO = LCG_MUL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] LCG_MUL_HI = LCG_MUL[KEY_W-1:HALF_W];

    // Phantom king flag positions inside rights_flags.
    localparam int FLAG_WK = 4;
    localparam int FLAG_WQ = 5;
    localparam int FLAG_BK = 6;
    localparam int FLAG_BQ = 7;

    localparam logic [KIND_FIELD_W-1:0] WHITE_KING_RESET = 4'd5;
    localparam logic [KIND_FIELD_W-1:0] BLACK_KING_RESET = 4'd11;

    typedef enum logic {
        OP_GEN  = 1'b0,
        OP_HASH = 1'b1
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED       = 3'd0,
        REG_WK_KIND    = 3'd1,
        REG_BK_KIND    = 3'd2,
        REG_WK_MASK    = 3'd3,
        REG_WQ_MASK    = 3'd4,
        REG_BK_MASK    = 3'd5,
        REG_BQ_MASK    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic load;
        logic run;
    } lcg_ctrl_t;

endpackage

`default_nettype wire

// File: design/zph_lcg.sv
`timescale 1ns / 1ps
`default_nettype none

module zph_lcg
    import zph_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lcg_ctrl_t         ctrl,
    input  wire logic [KEY_W-1:0]  seed,
    output logic      [KEY_W-1:0]  key,
    output logic                   done
);

    // One 32x32 multiplier computes x * LCG_MUL from three partial products.
    typedef enum logic [1:0] {
        PH_LOW,
        PH_CROSS_A,
        PH_CROSS_B,
        PH_FINISH
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    logic   done_reg;
    logic   done_next;

    logic [KEY_W-1:0]  x_reg;
    logic [KEY_W-1:0]  acc_reg;
    logic [KEY_W-1:0]  prod_reg;
    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [KEY_W-1:0]  mul_p;
    logic [KEY_W-1:0]  prod_shifted;

    always_comb
    begin
        case (phase_reg)
            PH_LOW:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = LCG_MUL_LO;
            end
            PH_CROSS_A:
            begin
                mul_a = x_reg[KEY_W-1:HALF_W];
                mul_b = LCG_MUL_LO;
            end
            PH_CROSS_B:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = LCG_MUL_HI;
            end
            default:
            begin
                mul_a = x_reg[HALF_W-1:0];
                mul_b = LCG_MUL_LO;
            end
        endcase
    end

    assign mul_p = KEY_W'(mul_a) * KEY_W'(mul_b);
    assign prod_shifted = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        if (ctrl.load || !ctrl.run)
        begin
            phase_next = PH_LOW;
        end
        else
        begin
            case (phase_reg)
                PH_LOW:     phase_next = PH_CROSS_A;
                PH_CROSS_A: phase_next = PH_CROSS_B;
                PH_CROSS_B: phase_next = PH_FINISH;
                PH_FINISH:
                begin
                    phase_next = PH_LOW;
                    done_next  = 1'b1;
                end
                default:    phase_next = PH_LOW;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LOW;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= seed;
        end
        else if (ctrl.run)
        begin
            case (phase_reg)
                PH_LOW:
                begin
                    prod_reg <= mul_p;
                end
                PH_CROSS_A:
                begin
                    acc_reg  <= prod_reg + LCG_ADD;
                    prod_reg <= mul_p;
                end
                PH_CROSS_B:
                begin
                    acc_reg  <= acc_reg + prod_shifted;
                    prod_reg <= mul_p;
                end
                PH_FINISH:
                begin
                    x_reg <= acc_reg + prod_shifted;
                end
                default:
                begin
                    prod_reg <= mul_p;
                end
            endcase
        end
    end

    assign key  = x_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: design/zph_key_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module zph_key_ram
    import zph_pkg::*;
#(
    parameter int DEPTH  = PIECE_KINDS_DEF * SQUARES + CASTLE_RIGHTS_DEF + SQUARES + 1,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [KEY_W-1:0]  wdata,
    output logic      [KEY_W-1:0]  rdata
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/zobrist_position_hash.sv
`timescale 1ns / 1ps
`default_nettype none

// Zobrist position hash. A generate command (opcode 0) reseeds a 64-bit
// linear congruential generator and fills one key memory of
// PIECE_KINDS*64 + CASTLE_RIGHTS + 65 words; each key takes three partial
// products of the single 32x32 multiplier, and busy stays high until the
// last key is written. A hash command walks all 64 squares of its bitboard,
// one key-memory read per cycle; on the last bitboard of a position the
// castle and side keys follow, one read each. The finished hash appears on
// position_hash with hash_valid for exactly one cycle, in the first cycle in
// which busy is low; the receiver cannot stall it. Configuration writes
// are always accepted and must only be issued while busy is low. Hashing
// before the first generate command returns undefined keys.
module zobrist_position_hash
    import zph_pkg::*;
#(
    parameter int PIECE_KINDS   = PIECE_KINDS_DEF,
    parameter int CASTLE_RIGHTS = CASTLE_RIGHTS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic                    opcode,
    input  wire logic [KIND_FIELD_W-1:0] piece_kind,
    input  wire logic [KEY_W-1:0]        board_bits,
    input  wire logic [FLAGS_W-1:0]      rights_flags,
    input  wire logic                    black_moves,
    input  wire logic                    last_word,
    output logic [KEY_W-1:0]             position_hash,
    output logic                         hash_valid,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [KEY_W-1:0]        cfg_data
);

    localparam int PIECE_KEYS  = PIECE_KINDS * SQUARES;
    localparam int CASTLE_BASE = PIECE_KEYS;
    localparam int EP_BASE     = PIECE_KEYS + CASTLE_RIGHTS;
    localparam int SIDE_ADDR   = EP_BASE + SQUARES;
    localparam int KEY_COUNT   = SIDE_ADDR + 1;
    localparam int ADDR_W      = $clog2(KEY_COUNT);
    localparam int KIND_W      = KIND_FIELD_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_SCAN,
        ST_CASTLE,
        ST_SIDE,
        ST_FLUSH
    } state_t;

    // Configuration registers.
    logic [KEY_W-1:0]        seed_reg;
    logic [KIND_FIELD_W-1:0] wk_kind_reg;
    logic [KIND_FIELD_W-1:0] bk_kind_reg;
    logic [KEY_W-1:0]        wk_mask_reg;
    logic [KEY_W-1:0]        wq_mask_reg;
    logic [KEY_W-1:0]        bk_mask_reg;
    logic [KEY_W-1:0]        bq_mask_reg;

    // Control state and registered outputs.
    state_t           state_reg;
    state_t           state_next;
    logic [KEY_W-1:0] acc_reg;
    logic [KEY_W-1:0] acc_next;
    logic [KEY_W-1:0] hash_reg;
    logic [KEY_W-1:0] hash_next;
    logic             hash_valid_reg;
    logic             hash_valid_next;
    logic             use_d_reg;
    logic             use_issue;

    // Per-transaction working registers.
    logic [KEY_W-1:0]         board_reg;
    logic [KEY_W-1:0]         board_next;
    logic [CASTLE_RIGHTS-1:0] castle_reg;
    logic [CASTLE_RIGHTS-1:0] castle_next;
    logic                     black_reg;
    logic                     black_next;
    logic                     last_reg;
    logic                     last_next;
    logic [ADDR_W-1:0]        addr_reg;
    logic [ADDR_W-1:0]        addr_next;
    logic [SQ_W-1:0]          cnt_reg;
    logic [SQ_W-1:0]          cnt_next;

    logic              accept;
    logic              in_piece;
    logic              in_ep;
    logic              wk_hit;
    logic              bk_hit;
    logic [KEY_W-1:0]  board_adj;
    logic [KEY_W-1:0]  board_load;
    logic [ADDR_W-1:0] base_load;
    logic [KEY_W-1:0]  key_q;
    logic [KEY_W-1:0]  contrib;
    logic              ram_we;
    lcg_ctrl_t         lcg_ctrl;
    logic [KEY_W-1:0]  lcg_key;
    logic              lcg_done;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= '0;
            wk_kind_reg <= WHITE_KING_RESET;
            bk_kind_reg <= BLACK_KING_RESET;
            wk_mask_reg <= '0;
            wq_mask_reg <= '0;
            bk_mask_reg <= '0;
            bq_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SEED:    seed_reg    <= cfg_data;
                REG_WK_KIND: wk_kind_reg <= cfg_data[KIND_FIELD_W-1:0];
                REG_BK_KIND: bk_kind_reg <= cfg_data[KIND_FIELD_W-1:0];
                REG_WK_MASK: wk_mask_reg <= cfg_data;
                REG_WQ_MASK: wq_mask_reg <= cfg_data;
                REG_BK_MASK: bk_mask_reg <= cfg_data;
                REG_BQ_MASK: bq_mask_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Input decode: phantom masks apply only to piece bitboards, and a kind
    // beyond the en passant code adds no square keys.
    assign in_piece = {1'b0, piece_kind} < KIND_W'(PIECE_KINDS);
    assign in_ep    = {1'b0, piece_kind} == KIND_W'(PIECE_KINDS);
    assign wk_hit   = in_piece && (piece_kind == wk_kind_reg);
    assign bk_hit   = in_piece && (piece_kind == bk_kind_reg);

    assign board_adj = board_bits
                     ^ ({KEY_W{wk_hit && rights_flags[FLAG_WK]}} & wk_mask_reg)
                     ^ ({KEY_W{wk_hit && rights_flags[FLAG_WQ]}} & wq_mask_reg)
                     ^ ({KEY_W{bk_hit && rights_flags[FLAG_BK]}} & bk_mask_reg)
                     ^ ({KEY_W{bk_hit && rights_flags[FLAG_BQ]}} & bq_mask_reg);

    assign board_load = (in_piece || in_ep) ? board_adj : '0;

    always_comb
    begin
        if (in_piece)
        begin
            base_load = ADDR_W'(piece_kind) << SQ_W;
        end
        else if (in_ep)
        begin
            base_load = ADDR_W'(EP_BASE);
        end
        else
        begin
            base_load = '0;
        end
    end

    assign contrib = use_d_reg ? key_q : '0;

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg ^ contrib;
        hash_next       = hash_reg;
        hash_valid_next = 1'b0;
        use_issue       = 1'b0;
        ram_we          = 1'b0;
        lcg_ctrl.load   = 1'b0;
        lcg_ctrl.run    = 1'b0;
        board_next      = board_reg;
        castle_next     = castle_reg;
        black_next      = black_reg;
        last_next       = last_reg;
        addr_next       = addr_reg;
        cnt_next        = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    board_next  = board_load;
                    castle_next = rights_flags[CASTLE_RIGHTS-1:0];
                    black_next  = black_moves;
                    last_next   = last_word;
                    cnt_next    = '0;
                    case (opcode)
                        OP_GEN:
                        begin
                            lcg_ctrl.load = 1'b1;
                            addr_next     = '0;
                            state_next    = ST_GEN;
                        end
                        OP_HASH:
                        begin
                            addr_next  = base_load;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_GEN:
            begin
                lcg_ctrl.run = 1'b1;
                if (lcg_done)
                begin
                    ram_we    = 1'b1;
                    addr_next = addr_reg + 1'b1;
                    if (addr_reg == ADDR_W'(KEY_COUNT - 1))
                    begin
                        addr_next  = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                use_issue  = board_reg[0];
                board_next = board_reg >> 1;
                addr_next  = addr_reg + 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == SQ_W'(SQUARES - 1))
                begin
                    cnt_next = '0;
                    if (last_reg)
                    begin
                        addr_next  = ADDR_W'(CASTLE_BASE);
                        state_next = ST_CASTLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_CASTLE:
            begin
                use_issue   = castle_reg[0];
                castle_next = castle_reg >> 1;
                addr_next   = addr_reg + 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == SQ_W'(CASTLE_RIGHTS - 1))
                begin
                    addr_next  = ADDR_W'(SIDE_ADDR);
                    state_next = ST_SIDE;
                end
            end
            ST_SIDE:
            begin
                use_issue  = black_reg;
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                // The last key read lands here; finish the hash on the final bitboard.
                state_next = ST_IDLE;
                if (last_reg)
                begin
                    hash_next       = acc_reg ^ contrib;
                    hash_valid_next = 1'b1;
                    acc_next        = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            acc_reg        <= '0;
            hash_reg       <= '0;
            hash_valid_reg <= 1'b0;
            use_d_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            acc_reg        <= acc_next;
            hash_reg       <= hash_next;
            hash_valid_reg <= hash_valid_next;
            use_d_reg      <= use_issue;
        end
    end

    always_ff @(posedge clk)
    begin
        board_reg  <= board_next;
        castle_reg <= castle_next;
        black_reg  <= black_next;
        last_reg   <= last_next;
        addr_reg   <= addr_next;
        cnt_reg    <= cnt_next;
    end

    zph_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lcg_ctrl),
        .seed  (seed_reg),
        .key   (lcg_key),
        .done  (lcg_done)
    );

    zph_key_ram #(
        .DEPTH  (KEY_COUNT),
        .ADDR_W (ADDR_W)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr_reg),
        .wdata (lcg_key),
        .rdata (key_q)
    );

    assign position_hash = hash_reg;
    assign hash_valid    = hash_valid_reg;

endmodule

`default_nettype wire

// File: design/zph_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "zobrist_position_hash_macros.svh"

module zph_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic hash_valid
);

    // A result strobe never lasts more than one cycle.
    `ZPH_ASSERT_NEXT(a_strobe_single, clk, rst_n, hash_valid, !hash_valid, "hash_valid held")

    // An accepted command keeps the block busy in the following cycle.
    `ZPH_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised")

    // A result only appears once the block has gone idle.
    `ZPH_ASSERT_IMPLY(a_result_idle, clk, rst_n, hash_valid, !busy, "result while busy")

    // The result follows directly on the end of a busy command.
    `ZPH_ASSERT_IMPLY(a_result_after_busy, clk, rst_n, hash_valid, $past(busy),
        "result without command")

endmodule

bind zobrist_position_hash zph_checker u_zph_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import zph_pkg::*;

    localparam int N_KINDS = PIECE_KINDS_DEF;
    localparam int N_CASTLE = CASTLE_RIGHTS_DEF;
    localparam int N_SQUARES = 64;
    localparam int N_PIECE_KEYS = N_KINDS * N_SQUARES;
    localparam logic [63:0] KEY_STEP_MUL = 64'd8 * 64'd893636665409536 - 64'd3;
    localparam logic [63:0] KEY_STEP_ADD = 64'd4354685564936845319;
    localparam int WK_BIT = 4;
    localparam int WQ_BIT = 5;
    localparam int BK_BIT = 6;
    localparam int BQ_BIT = 7;
    localparam logic [3:0] EP_KIND = 4'd12;
    localparam int SETTLE_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES = 8;
    localparam int RANDOM_ITEMS = 870;

    typedef struct {
        logic [63:0] seed;
        logic [3:0]  wk_kind;
        logic [3:0]  bk_kind;
        logic [63:0] wk_mask;
        logic [63:0] wq_mask;
        logic [63:0] bk_mask;
        logic [63:0] bq_mask;
    } hash_setting_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        opcode = 1'b0;
    logic [3:0]  piece_kind = '0;
    logic [63:0] board_bits = '0;
    logic [7:0]  rights_flags = '0;
    logic        black_moves = 1'b0;
    logic        last_word = 1'b0;
    logic [63:0] position_hash;
    logic        hash_valid;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // Local copy of the block's configuration and key tables.
    hash_setting_t active_cfg = '{64'd0, 4'd5, 4'd11, 64'd0, 64'd0, 64'd0, 64'd0};
    logic [63:0] piece_keys [0:N_PIECE_KEYS-1];
    logic [63:0] castle_keys [0:N_CASTLE-1];
    logic [63:0] ep_keys [0:N_SQUARES-1];
    logic [63:0] side_key;
    logic [63:0] running_hash = '0;

    logic [63:0] expected_hashes [$];
    logic [63:0] popped_hash;
    int          failures = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;

    zobrist_position_hash u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .piece_kind   (piece_kind),
        .board_bits   (board_bits),
        .rights_flags (rights_flags),
        .black_moves  (black_moves),
        .last_word    (last_word),
        .position_hash(position_hash),
        .hash_valid   (hash_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic note_failure(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        failures++;
        if (failures <= 10)
            $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    endtask

    task automatic refill_keys();
        logic [63:0] lcg;
        lcg = active_cfg.seed;
        for (int i = 0; i < N_PIECE_KEYS; i++)
        begin
            lcg = lcg * KEY_STEP_MUL + KEY_STEP_ADD;
            piece_keys[i] = lcg;
        end
        for (int i = 0; i < N_CASTLE; i++)
        begin
            lcg = lcg * KEY_STEP_MUL + KEY_STEP_ADD;
            castle_keys[i] = lcg;
        end
        for (int i = 0; i < N_SQUARES; i++)
        begin
            lcg = lcg * KEY_STEP_MUL + KEY_STEP_ADD;
            ep_keys[i] = lcg;
        end
        lcg = lcg * KEY_STEP_MUL + KEY_STEP_ADD;
        side_key = lcg;
    endtask

    task automatic hash_model_step(input opcode_t op, input logic [3:0] kind,
                                   input logic [63:0] bits, input logic [7:0] flags,
                                   input logic black, input logic last);
        logic [63:0] b;
        b = bits;
        if (op == OP_GEN)
        begin
            refill_keys();
            return;
        end
        if (kind < N_KINDS)
        begin
            // Phantom masks only touch piece bitboards; both sets apply if the kinds match.
            if (kind == active_cfg.wk_kind)
            begin
                if (flags[WK_BIT]) b ^= active_cfg.wk_mask;
                if (flags[WQ_BIT]) b ^= active_cfg.wq_mask;
            end
            if (kind == active_cfg.bk_kind)
            begin
                if (flags[BK_BIT]) b ^= active_cfg.bk_mask;
                if (flags[BQ_BIT]) b ^= active_cfg.bq_mask;
            end
            for (int sq = 0; sq < N_SQUARES; sq++)
                if (b[sq]) running_hash ^= piece_keys[kind * N_SQUARES + sq];
        end
        else if (kind == EP_KIND)
        begin
            for (int sq = 0; sq < N_SQUARES; sq++)
                if (b[sq]) running_hash ^= ep_keys[sq];
        end
        if (!last)
            return;
        for (int i = 0; i < N_CASTLE; i++)
            if (flags[i]) running_hash ^= castle_keys[i];
        if (black)
            running_hash ^= side_key;
        expected_hashes.push_back(running_hash);
        running_hash = '0;
    endtask

    // One command transaction. Start stays high across a burst; it drops only between bursts.
    task automatic send_item(input opcode_t op, input logic [3:0] kind,
                             input logic [63:0] bits, input logic [7:0] flags,
                             input logic black, input logic last);
        start        <= 1'b1;
        opcode       <= op;
        piece_kind   <= kind;
        board_bits   <= bits;
        rights_flags <= flags;
        black_moves  <= black;
        last_word    <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        items_sent++;
        hash_model_step(op, kind, bits, flags, black, last);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 90)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Lets the block go idle: no pending hash and no generate still running.
    task automatic wait_quiet();
        start <= 1'b0;
        while (expected_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic apply_setting(input hash_setting_t s);
        cfg_reg_t    regs [7];
        logic [63:0] vals [7];
        regs = '{REG_SEED, REG_WK_KIND, REG_BK_KIND, REG_WK_MASK,
                 REG_WQ_MASK, REG_BK_MASK, REG_BQ_MASK};
        // Upper bits of the kind registers are ignored by the block.
        vals = '{s.seed, {$urandom, 28'($urandom), s.wk_kind},
                 {$urandom, 28'($urandom), s.bk_kind},
                 s.wk_mask, s.wq_mask, s.bk_mask, s.bq_mask};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 7; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        active_cfg = s;
    endtask

    function automatic logic [63:0] random_board();
        logic [63:0] b;
        int n;
        b = '0;
        case ($urandom_range(0, 7))
            0: b = '0;
            1: b = '1;
            2, 3: b = {$urandom, $urandom};
            default:
            begin
                n = $urandom_range(1, 8);
                repeat (n) b[$urandom_range(0, 63)] = 1'b1;
            end
        endcase
        return b;
    endfunction

    function automatic logic [3:0] random_king_kind();
        if ($urandom_range(0, 4) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, N_KINDS - 1));
    endfunction

    task automatic test_default_setting();
        // Reset seed and king kinds; masks are zero, so phantom flags change nothing.
        send_item(OP_GEN, 4'd0, '0, 8'h00, 1'b0, 1'b0);
        send_item(OP_HASH, 4'd5, 64'h0000_0000_0000_0010, 8'hF0, 1'b0, 1'b0);
        send_item(OP_HASH, 4'd0, 64'h0000_0000_0000_0001, 8'h00, 1'b0, 1'b0);
        send_item(OP_HASH, 4'd11, 64'h8000_0000_0000_0000, 8'h0F, 1'b1, 1'b1);
        wait_quiet();
    endtask

    task automatic test_extreme_fields();
        apply_setting('{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 4'd15, '1, '0, '1, '1});
        send_item(OP_GEN, 4'd15, '1, 8'hFF, 1'b1, 1'b1);
        send_item(OP_HASH, 4'd0, '1, 8'hFF, 1'b0, 1'b0);
        send_item(OP_HASH, 4'd11, '0, 8'h00, 1'b0, 1'b0);
        send_item(OP_HASH, EP_KIND, '1, 8'h00, 1'b0, 1'b0);
        // Kinds past the en passant code add no square keys but still finish the position.
        send_item(OP_HASH, 4'd13, {$urandom, $urandom}, 8'hFF, 1'b1, 1'b1);
        send_item(OP_HASH, 4'd15, '1, 8'h00, 1'b0, 1'b1);
        // A generate in the middle of a position leaves the running hash alone.
        send_item(OP_HASH, 4'd3, {$urandom, $urandom}, 8'h05, 1'b0, 1'b0);
        send_item(OP_GEN, 4'd3, '0, 8'h00, 1'b0, 1'b1);
        send_item(OP_HASH, EP_KIND, 64'h0000_0000_00FF_0000, 8'h0A, 1'b1, 1'b1);
        wait_quiet();
    endtask

    task automatic test_phantom_masks();
        apply_setting('{{$urandom, $urandom}, 4'd7, 4'd7, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}});
        send_item(OP_GEN, 4'd0, '0, 8'h00, 1'b0, 1'b0);
        send_item(OP_HASH, 4'd7, 64'h0000_0000_0000_0010, 8'h10, 1'b0, 1'b1);
        send_item(OP_HASH, 4'd7, 64'h0000_0000_0000_0010, 8'h20, 1'b1, 1'b1);
        send_item(OP_HASH, 4'd7, 64'h1000_0000_0000_0000, 8'h40, 1'b0, 1'b1);
        send_item(OP_HASH, 4'd7, 64'h1000_0000_0000_0000, 8'h80, 1'b1, 1'b1);
        send_item(OP_HASH, 4'd7, '0, 8'hFF, 1'b0, 1'b1);
        wait_quiet();
        // King kinds that name no piece bitboard never take the masks.
        apply_setting('{active_cfg.seed, EP_KIND, 4'd15, '1, '1, '1, '1});
        send_item(OP_HASH, EP_KIND, 64'h0000_0000_0000_0100, 8'hF0, 1'b0, 1'b0);
        send_item(OP_HASH, 4'd15, 64'h0000_0000_0000_0100, 8'hF0, 1'b0, 1'b1);
        wait_quiet();
    endtask

    task automatic test_random_positions();
        hash_setting_t s;
        logic [7:0] flags;
        logic       black;
        int         n;
        int         target;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 3)
                0: s.seed = '0;
                1: s.seed = '1;
                default: s.seed = {$urandom, $urandom};
            endcase
            s.wk_kind = random_king_kind();
            s.bk_kind = ($urandom_range(0, 5) == 0) ? s.wk_kind : random_king_kind();
            s.wk_mask = random_board();
            s.wq_mask = random_board();
            s.bk_mask = random_board();
            s.bq_mask = random_board();
            apply_setting(s);
            send_item(OP_GEN, 4'($urandom), {$urandom, $urandom}, 8'($urandom),
                      1'($urandom), 1'($urandom));
            target = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < target)
            begin
                n = $urandom_range(0, 99);
                if (n < 2)
                    send_item(OP_GEN, 4'($urandom), {$urandom, $urandom}, 8'($urandom),
                              1'($urandom), 1'($urandom));
                else if (n < 82)
                begin
                    // Well-formed position: several bitboards that share one flag byte.
                    flags = 8'($urandom);
                    black = 1'($urandom);
                    n = $urandom_range(1, 13);
                    for (int j = 0; j < n; j++)
                        send_item(OP_HASH, 4'($urandom_range(0, N_KINDS)), random_board(),
                                  flags, black, j == n - 1);
                end
                else
                    send_item(OP_HASH, 4'($urandom), random_board(), 8'($urandom),
                              1'($urandom), 1'($urandom));
            end
            wait_quiet();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_setting();
        test_extreme_fields();
        test_phantom_masks();
        test_random_positions();
        wait_quiet();
        failures += expected_hashes.size();
        if (failures == 0)
            $display("zobrist_position_hash test passed");
        else
            $display("zobrist_position_hash test failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && hash_valid)
        begin
            if (expected_hashes.size() == 0)
                note_failure("hash with no position pending", '0, position_hash);
            else
            begin
                popped_hash = expected_hashes.pop_front();
                if (position_hash !== popped_hash)
                    note_failure("position_hash mismatch", popped_hash, position_hash);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || hash_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("zobrist_position_hash test failed");
            $finish;
        end
    end

endmodule

// File: sim.f
+incdir+design
design/zph_pkg.sv
design/zph_lcg.sv
design/zph_key_ram.sv
design/zobrist_position_hash.sv
design/zph_checker.sv
test/tb_top.sv
